// ===== src/pso_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed slot offset: shared package
// Types, constants and helper functions shared by the sequencer, the
// microcode table and the datapath.
// ----------------------------------------------------------------------------
package pso_pkg;

  // Operation codes carried in the input tuser.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Field widths fixed by the interface.
  localparam int SLOT_W     = 5;
  localparam int ENTRY_W    = 12;
  localparam int ALIGN_W    = 3;
  localparam int MAP_W      = 32;
  localparam int OFFSET_W   = 18;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

  // Microcode step addresses.
  typedef enum logic [2:0] {
    STEP_DISPATCH,
    STEP_CHECK,
    STEP_WALK,
    STEP_ALIGN,
    STEP_EMIT
  } step_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_IDLE_OR_LOAD,
    COND_ABSENT,
    COND_WALK_MORE
  } cond_t;

  // One control word of the microcode table.
  typedef struct packed {
    logic  in_ready;
    logic  walk_en;
    logic  align_en;
    logic  wait_out;
    logic  out_load;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Status flags fed back from the datapath to the sequencer.
  typedef struct packed {
    logic idle_or_load;
    logic absent;
    logic walk_more;
    logic out_busy;
  } status_t;

  // Round an offset up to a power-of-two alignment; one spare top bit
  // shows an overflow past the offset range.
  function automatic logic [OFFSET_W:0] align_up(input logic [OFFSET_W-1:0] v,
                                                 input logic [ALIGN_W-1:0]  a);
    logic [OFFSET_W:0] mask;
    mask = ((OFFSET_W+1)'(1) << a) - (OFFSET_W+1)'(1);
    return ({1'b0, v} + mask) & ~mask;
  endfunction

endpackage

// ===== src/pso_ucode_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed slot offset: microcode table
// Read-only control program, one control word per step.
// ----------------------------------------------------------------------------
module pso_ucode_rom (
  input  pso_pkg::step_t      pc,
  output pso_pkg::ctrl_word_t word
);

  // Program: dispatch, presence check, walk of lower slots, final
  // alignment, hand-off to the output register.
  always_comb begin
    word = '{in_ready: 1'b0, walk_en: 1'b0, align_en: 1'b0, wait_out: 1'b0,
             out_load: 1'b0, cond: pso_pkg::COND_ALWAYS,
             target: pso_pkg::STEP_DISPATCH};
    case (pc)
      pso_pkg::STEP_DISPATCH: begin
        word.in_ready = 1'b1;
        word.cond     = pso_pkg::COND_IDLE_OR_LOAD;
        word.target   = pso_pkg::STEP_DISPATCH;
      end
      pso_pkg::STEP_CHECK: begin
        word.cond   = pso_pkg::COND_ABSENT;
        word.target = pso_pkg::STEP_EMIT;
      end
      pso_pkg::STEP_WALK: begin
        word.walk_en = 1'b1;
        word.cond    = pso_pkg::COND_WALK_MORE;
        word.target  = pso_pkg::STEP_WALK;
      end
      pso_pkg::STEP_ALIGN: begin
        word.align_en = 1'b1;
        word.cond     = pso_pkg::COND_NEXT;
      end
      pso_pkg::STEP_EMIT: begin
        word.wait_out = 1'b1;
        word.out_load = 1'b1;
        word.cond     = pso_pkg::COND_ALWAYS;
        word.target   = pso_pkg::STEP_DISPATCH;
      end
      default: begin
        word.cond   = pso_pkg::COND_ALWAYS;
        word.target = pso_pkg::STEP_DISPATCH;
      end
    endcase
  end

endmodule

// ===== src/pso_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed slot offset: sequencer
// Step counter with conditional jumps over the microcode table.
// ----------------------------------------------------------------------------
module pso_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  pso_pkg::status_t    status,
  output pso_pkg::ctrl_word_t ctrl
);

  pso_pkg::step_t pc;
  pso_pkg::step_t pc_next;
  logic           taken;
  logic           stall;

  pso_ucode_rom u_rom (
    .pc   (pc),
    .word (ctrl)
  );

  // Evaluate the jump condition of the current step.
  always_comb begin
    case (ctrl.cond)
      pso_pkg::COND_NEXT:         taken = 1'b0;
      pso_pkg::COND_ALWAYS:       taken = 1'b1;
      pso_pkg::COND_IDLE_OR_LOAD: taken = status.idle_or_load;
      pso_pkg::COND_ABSENT:       taken = status.absent;
      pso_pkg::COND_WALK_MORE:    taken = status.walk_more;
      default:                    taken = 1'b1;
    endcase
  end

  // A step that hands over a result holds while the output register is full.
  assign stall = ctrl.wait_out & status.out_busy;

  always_comb begin
    if (stall) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pso_pkg::step_t'(pc + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= pso_pkg::STEP_DISPATCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== src/pso_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed slot offset: datapath
// Slot table memory, query registers, offset accumulator and result register.
// ----------------------------------------------------------------------------
module pso_datapath #(
  parameter int SLOT_COUNT = 32,
  parameter int SIZE_BITS  = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pso_pkg::ctrl_word_t             ctrl,
  input  logic                            in_valid,
  input  logic                            op,
  input  logic [pso_pkg::SLOT_W-1:0]      slot_index,
  input  logic [pso_pkg::ENTRY_W-1:0]     entry_size,
  input  logic [pso_pkg::ALIGN_W-1:0]     entry_align_log2,
  input  logic [pso_pkg::MAP_W-1:0]       presence_map,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            present,
  output logic [pso_pkg::OFFSET_W-1:0]    byte_offset,
  output pso_pkg::status_t                status
);

  localparam int ADDR_W  = $clog2(SLOT_COUNT);
  localparam int ENTRY_T = SIZE_BITS + pso_pkg::ALIGN_W;
  localparam int SUM_W   = ((SIZE_BITS > pso_pkg::OFFSET_W + 1) ? SIZE_BITS
                                                                : pso_pkg::OFFSET_W + 1) + 1;
  localparam logic [pso_pkg::OFFSET_W-1:0] MAP_BYTES =
    pso_pkg::OFFSET_W'((SLOT_COUNT + 7) / 8);

  // Slot table: size in the upper bits, alignment in the lower bits.
  logic [ENTRY_T-1:0] table_mem [SLOT_COUNT];
  logic [ENTRY_T-1:0] rd_entry;

  logic                           accept;
  logic                           load_wr;
  logic                           stall;
  logic [ADDR_W-1:0]              cnt;
  logic [ADDR_W-1:0]              slot_q;
  logic [pso_pkg::MAP_W-1:0]      map_q;
  logic                           present_q;
  logic [pso_pkg::OFFSET_W-1:0]   off;
  logic                           sat;
  logic [ADDR_W-1:0]              pidx;
  logic [pso_pkg::SLOT_W-1:0]     pidx_map;
  logic [SIZE_BITS-1:0]           rd_size;
  logic [pso_pkg::ALIGN_W-1:0]    rd_align;
  logic [pso_pkg::OFFSET_W:0]     aligned;
  logic [SUM_W-1:0]               sum;
  logic                           in_range;

  assign accept   = in_valid & ctrl.in_ready;
  assign in_range = 32'(slot_index) < SLOT_COUNT;
  assign load_wr  = accept & (op == pso_pkg::OP_LOAD) & in_range;
  assign stall    = ctrl.wait_out & out_valid & ~out_ready;

  // Table write on a load and registered read at the walk counter.
  always_ff @(posedge clk) begin
    if (load_wr) begin
      table_mem[ADDR_W'(slot_index)] <= {SIZE_BITS'(entry_size), entry_align_log2};
    end
    rd_entry <= table_mem[cnt];
  end

  assign rd_size  = rd_entry[ENTRY_T-1:pso_pkg::ALIGN_W];
  assign rd_align = rd_entry[pso_pkg::ALIGN_W-1:0];

  // The read data in a walk step belongs to the slot one below the counter.
  assign pidx     = cnt - ADDR_W'(1);
  assign pidx_map = pso_pkg::SLOT_W'(pidx);
  assign aligned  = pso_pkg::align_up(off, rd_align);
  assign sum      = SUM_W'(aligned) + SUM_W'(rd_size);

  // Query registers, walk counter and offset accumulator.
  always_ff @(posedge clk) begin
    if (accept && op == pso_pkg::OP_QUERY) begin
      slot_q    <= ADDR_W'(slot_index);
      map_q     <= presence_map;
      present_q <= in_range & presence_map[slot_index];
      cnt       <= '0;
      off       <= MAP_BYTES;
      sat       <= 1'b0;
    end else if (ctrl.walk_en) begin
      cnt <= cnt + ADDR_W'(1);
      if (cnt != '0 && map_q[pidx_map]) begin
        off <= pso_pkg::OFFSET_W'(sum);
        if (sum > SUM_W'(pso_pkg::OFFSET_MAX)) begin
          sat <= 1'b1;
        end
      end
    end else if (ctrl.align_en) begin
      off <= aligned[pso_pkg::OFFSET_W-1:0];
      sat <= sat | aligned[pso_pkg::OFFSET_W];
    end
  end

  // Result register; it frees the sequencer as soon as it is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load && !stall) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load && !stall) begin
      present <= present_q;
      if (!present_q) begin
        byte_offset <= '0;
      end else if (sat) begin
        byte_offset <= pso_pkg::OFFSET_MAX;
      end else begin
        byte_offset <= off;
      end
    end
  end

  // Status back to the sequencer.
  assign status.idle_or_load = ~(in_valid & (op == pso_pkg::OP_QUERY));
  assign status.absent       = ~present_q;
  assign status.walk_more    = cnt != slot_q;
  assign status.out_busy     = out_valid & ~out_ready;

endmodule

// ===== src/packed_slot_offset_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed slot offset core
// Slot size and alignment table with a microcoded offset walk per query.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel (s_*) takes items; s_tuser is the operation, 0 to load
//   one slot's size and alignment, 1 to query a slot's payload offset.
//   A load transaction produces no result and the core takes the next item in
//   the following cycle. A query produces one transaction on the master
//   channel (m_*): m_tuser flags the slot present, m_tdata its byte offset.
//   A query for slot s runs through one presence check, one walk step per
//   lower slot plus one for the table read pipeline, one final alignment
//   and one hand-off; an absent slot goes from the presence check straight
//   to the hand-off. The walk reads one table entry per cycle through the
//   single memory read port. The result sits in an output register, so the
//   core returns to taking items while the receiver stalls; a second result
//   waits in the hand-off step until the register is free. Reset empties
//   the output register and returns the sequencer to dispatch; the table
//   holds no valid data until entries are loaded.
// ----------------------------------------------------------------------------
module packed_slot_offset_core #(
  parameter int SLOT_COUNT = 32,
  parameter int SIZE_BITS  = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [4:0] slot_index, [16:5] entry_size, [19:17] entry_align_log2,
  // [51:20] presence_map, [55:52] zero
  input  logic [pso_pkg::IN_DATA_W-1:0]    s_tdata,
  // [0] op
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [17:0] byte_offset, [23:18] zero
  output logic [pso_pkg::OUT_DATA_W-1:0]   m_tdata,
  // [0] present
  output logic                             m_tuser
);

  pso_pkg::ctrl_word_t           ctrl;
  pso_pkg::status_t              status;
  logic [pso_pkg::OFFSET_W-1:0]  byte_offset;

  pso_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  pso_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .in_valid         (s_tvalid),
    .op               (s_tuser),
    .slot_index       (s_tdata[4:0]),
    .entry_size       (s_tdata[16:5]),
    .entry_align_log2 (s_tdata[19:17]),
    .presence_map     (s_tdata[51:20]),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .present          (m_tuser),
    .byte_offset      (byte_offset),
    .status           (status)
  );

  // Handshake and result packing.
  assign s_tready = ctrl.in_ready;
  assign m_tdata  = pso_pkg::OUT_DATA_W'(byte_offset);

endmodule
